// ----- hw/rtl/sau_pkg.sv -----
package sau_pkg;

    // Word width of the stack and of the arithmetic unit
    localparam int WORD_W = 32;

    // Default number of stack entries
    localparam int STACK_DEPTH_DEF = 64;

    // Command codes
    localparam logic [2:0] CMD_PUSH = 3'd0;
    localparam logic [2:0] CMD_ADD  = 3'd1;
    localparam logic [2:0] CMD_SUB  = 3'd2;
    localparam logic [2:0] CMD_MUL  = 3'd3;
    localparam logic [2:0] CMD_DIV  = 3'd4;
    localparam logic [2:0] CMD_MOD  = 3'd5;

    // Status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_SHORT   = 2'd1;
    localparam logic [1:0] ST_DIVZERO = 2'd2;
    localparam logic [1:0] ST_FULL    = 2'd3;

    // Input item
    typedef struct packed {
        logic [2:0]               command;
        logic signed [WORD_W-1:0] push_value;
    } t_in;

    // Result item
    typedef struct packed {
        logic [1:0]               status;
        logic signed [WORD_W-1:0] top_value;
        logic [6:0]               stack_depth;
    } t_out;

    // Request to the arithmetic unit
    typedef struct packed {
        logic              start;
        logic [2:0]        op;
        logic [WORD_W-1:0] a;
        logic [WORD_W-1:0] b;
    } t_alu_req;

    // Completion from the arithmetic unit
    typedef struct packed {
        logic              done;
        logic [WORD_W-1:0] result;
    } t_alu_sts;

endpackage

// ----- hw/rtl/sau_alu.sv -----
module sau_alu (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  sau_pkg::t_alu_req i_req,
    output sau_pkg::t_alu_sts o_sts
);

    localparam int W  = sau_pkg::WORD_W;
    localparam int CW = $clog2(sau_pkg::WORD_W);

    typedef enum logic [6:0] {
        P_IDLE  = 7'b0000001,
        P_ONE   = 7'b0000010,
        P_MUL   = 7'b0000100,
        P_ABS_A = 7'b0001000,
        P_ABS_B = 7'b0010000,
        P_DIV   = 7'b0100000,
        P_FIX   = 7'b1000000
    } t_phase;

    t_phase         r_phase, n_phase;
    logic [W-1:0]   r_a, n_a;       // operand A, multiplicand, quotient
    logic [W-1:0]   r_b, n_b;       // operand B, multiplier, divisor
    logic [W-1:0]   r_rem, n_rem;   // product accumulator or remainder
    logic [CW-1:0]  r_cnt, n_cnt;
    logic [2:0]     r_op, n_op;
    logic           r_neg_q, n_neg_q;
    logic           r_neg_r, n_neg_r;
    logic           r_done, n_done;
    logic [W-1:0]   r_result, n_result;

    // Shared adder / subtractor, one bit wider for the divide compare
    logic [W:0]     add_a, add_b, sum;
    logic           add_sub;
    logic [W-1:0]   rem_sh;
    logic [W-1:0]   fix_val;
    logic           fix_neg;

    assign rem_sh  = {r_rem[W-2:0], r_a[W-1]};
    assign fix_val = (r_op == sau_pkg::CMD_MOD) ? r_rem : r_a;
    assign fix_neg = (r_op == sau_pkg::CMD_MOD) ? r_neg_r : r_neg_q;

    // Operand selection for the shared adder
    always_comb begin
        add_a   = '0;
        add_b   = '0;
        add_sub = 1'b0;
        case (r_phase)
            P_ONE: begin
                add_a   = {1'b0, r_a};
                add_b   = {1'b0, r_b};
                add_sub = (r_op == sau_pkg::CMD_SUB);
            end
            P_MUL: begin
                add_a = {1'b0, r_rem};
                add_b = {1'b0, r_a};
            end
            P_ABS_A: begin
                add_b   = {1'b0, r_a};
                add_sub = 1'b1;
            end
            P_ABS_B: begin
                add_b   = {1'b0, r_b};
                add_sub = 1'b1;
            end
            P_DIV: begin
                add_a   = {1'b0, rem_sh};
                add_b   = {1'b0, r_b};
                add_sub = 1'b1;
            end
            P_FIX: begin
                add_b   = {1'b0, fix_val};
                add_sub = 1'b1;
            end
            default: begin
                add_a   = '0;
                add_b   = '0;
                add_sub = 1'b0;
            end
        endcase
        sum = add_a + (add_sub ? ~add_b : add_b) + {{W{1'b0}}, add_sub};
    end

    // Sequencer
    always_comb begin
        n_phase  = r_phase;
        n_a      = r_a;
        n_b      = r_b;
        n_rem    = r_rem;
        n_cnt    = r_cnt;
        n_op     = r_op;
        n_neg_q  = r_neg_q;
        n_neg_r  = r_neg_r;
        n_done   = 1'b0;
        n_result = r_result;
        case (r_phase)
            P_IDLE: begin
                if (i_req.start) begin
                    n_a     = i_req.a;
                    n_b     = i_req.b;
                    n_op    = i_req.op;
                    n_rem   = '0;
                    n_cnt   = '0;
                    n_neg_q = i_req.a[W-1] ^ i_req.b[W-1];
                    n_neg_r = i_req.a[W-1];
                    if (i_req.op == sau_pkg::CMD_ADD || i_req.op == sau_pkg::CMD_SUB) begin
                        n_phase = P_ONE;
                    end else if (i_req.op == sau_pkg::CMD_MUL) begin
                        n_phase = P_MUL;
                    end else begin
                        n_phase = P_ABS_A;
                    end
                end
            end
            P_ONE: begin
                n_result = sum[W-1:0];
                n_done   = 1'b1;
                n_phase  = P_IDLE;
            end
            // Shift-and-add, one multiplier bit a cycle
            P_MUL: begin
                if (r_b[0]) begin
                    n_rem = sum[W-1:0];
                end
                n_a   = {r_a[W-2:0], 1'b0};
                n_b   = {1'b0, r_b[W-1:1]};
                n_cnt = r_cnt + CW'(1);
                if (r_cnt == CW'(W - 1)) begin
                    n_result = r_b[0] ? sum[W-1:0] : r_rem;
                    n_done   = 1'b1;
                    n_phase  = P_IDLE;
                end
            end
            P_ABS_A: begin
                if (r_a[W-1]) begin
                    n_a = sum[W-1:0];
                end
                n_phase = P_ABS_B;
            end
            P_ABS_B: begin
                if (r_b[W-1]) begin
                    n_b = sum[W-1:0];
                end
                n_phase = P_DIV;
            end
            // Restoring division on magnitudes, one quotient bit a cycle
            P_DIV: begin
                n_rem = sum[W] ? rem_sh : sum[W-1:0];
                n_a   = {r_a[W-2:0], ~sum[W]};
                n_cnt = r_cnt + CW'(1);
                if (r_cnt == CW'(W - 1)) begin
                    n_phase = P_FIX;
                end
            end
            // Sign correction of quotient or remainder
            P_FIX: begin
                n_result = fix_neg ? sum[W-1:0] : fix_val;
                n_done   = 1'b1;
                n_phase  = P_IDLE;
            end
            default: begin
                n_phase = P_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= P_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_done  <= n_done;
        end
        r_a      <= n_a;
        r_b      <= n_b;
        r_rem    <= n_rem;
        r_cnt    <= n_cnt;
        r_op     <= n_op;
        r_neg_q  <= n_neg_q;
        r_neg_r  <= n_neg_r;
        r_result <= n_result;
    end

    assign o_sts.done   = r_done;
    assign o_sts.result = r_result;

endmodule

// ----- hw/rtl/stack_arithmetic_unit.sv -----
// Stack arithmetic unit: a bounded stack of signed 32-bit words.
// Input channel (i_in_valid / o_in_ready / i_in_data): one command per
// transfer, push with a value, or add, sub, mul, div, mod on the top two
// entries (second op top). Output channel (o_out_valid / i_out_ready /
// o_out_data): one result per command with status, new top and depth.
// Push, failed or unknown commands go from decode straight to the output
// register; add, sub, mul, div and mod first read the RAM and then wait
// for the shared adder of the arithmetic unit: mul takes one multiplier
// bit a cycle, div and mod one quotient bit a cycle plus sign steps.
// One command is in work at a time: o_in_ready is high only while the
// sequencer is idle, once the last result is in the output register.
// The top entry is held in a register and the rest in a single-port RAM,
// one read per arithmetic command that is carried out.
// Reset empties the stack at once (depth zero); no clearing pass. If the
// receiver stalls, the result is held in the output register and the next
// command is still taken; its result waits until the register is free.
module stack_arithmetic_unit #(
    parameter int STACK_DEPTH = sau_pkg::STACK_DEPTH_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  sau_pkg::t_in  i_in_data,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output sau_pkg::t_out o_out_data
);

    localparam int W  = sau_pkg::WORD_W;
    localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int DW = $clog2(STACK_DEPTH + 1);

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_DECODE = 5'b00010,
        S_READ   = 5'b00100,
        S_CALC   = 5'b01000,
        S_PUT    = 5'b10000
    } t_state;

    t_state             r_state, n_state;
    logic [2:0]         r_cmd, n_cmd;
    logic [W-1:0]       r_val, n_val;
    logic [W-1:0]       r_top, n_top;
    logic [DW-1:0]      r_depth, n_depth;
    logic [1:0]         r_status, n_status;
    logic [W-1:0]       r_rd_data;
    logic               r_out_valid, n_out_valid;
    sau_pkg::t_out      r_out_data, n_out_data;

    logic [W-1:0]       mem [STACK_DEPTH];
    logic               wr_en, rd_en;
    logic [DW-1:0]      depth_m1, depth_m2;
    logic [DW+6:0]      depth_ext;
    logic               is_arith, is_divmod, out_free;

    sau_pkg::t_alu_req  alu_req;
    sau_pkg::t_alu_sts  alu_sts;

    assign depth_m1  = r_depth - DW'(1);
    assign depth_m2  = r_depth - DW'(2);
    assign depth_ext = {7'b0, r_depth};
    assign is_arith  = (r_cmd inside {sau_pkg::CMD_ADD, sau_pkg::CMD_SUB, sau_pkg::CMD_MUL,
                                      sau_pkg::CMD_DIV, sau_pkg::CMD_MOD});
    assign is_divmod = (r_cmd == sau_pkg::CMD_DIV) || (r_cmd == sau_pkg::CMD_MOD);
    assign out_free  = !r_out_valid || i_out_ready;

    // Arithmetic unit: A is the RAM entry below the top, B the top register
    assign alu_req.start = (r_state == S_READ);
    assign alu_req.op    = r_cmd;
    assign alu_req.a     = r_rd_data;
    assign alu_req.b     = r_top;

    sau_alu u_alu (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (alu_req),
        .o_sts   (alu_sts)
    );

    // Command sequencer
    always_comb begin
        n_state     = r_state;
        n_cmd       = r_cmd;
        n_val       = r_val;
        n_top       = r_top;
        n_depth     = r_depth;
        n_status    = r_status;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out_data  = r_out_data;
        wr_en       = 1'b0;
        rd_en       = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_cmd   = i_in_data.command;
                    n_val   = i_in_data.push_value;
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                n_status = sau_pkg::ST_OK;
                n_state  = S_PUT;
                if (r_cmd == sau_pkg::CMD_PUSH) begin
                    if (r_depth == DW'(STACK_DEPTH)) begin
                        n_status = sau_pkg::ST_FULL;
                    end else begin
                        // old top moves down into the RAM
                        wr_en   = (r_depth != '0);
                        n_top   = r_val;
                        n_depth = r_depth + DW'(1);
                    end
                end else if (is_arith) begin
                    if (r_depth < DW'(2)) begin
                        n_status = sau_pkg::ST_SHORT;
                    end else if (is_divmod && r_top == '0) begin
                        n_status = sau_pkg::ST_DIVZERO;
                    end else begin
                        rd_en   = 1'b1;
                        n_state = S_READ;
                    end
                end
            end
            S_READ: begin
                n_state = S_CALC;
            end
            S_CALC: begin
                if (alu_sts.done) begin
                    n_top   = alu_sts.result;
                    n_depth = depth_m1;
                    n_state = S_PUT;
                end
            end
            S_PUT: begin
                if (out_free) begin
                    n_out_valid            = 1'b1;
                    n_out_data.status      = r_status;
                    n_out_data.top_value   = (r_depth == '0) ? '0 : r_top;
                    n_out_data.stack_depth = depth_ext[6:0];
                    n_state                = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_depth     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_depth     <= n_depth;
            r_out_valid <= n_out_valid;
        end
        r_cmd      <= n_cmd;
        r_val      <= n_val;
        r_top      <= n_top;
        r_status   <= n_status;
        r_out_data <= n_out_data;
    end

    // Stack RAM: entries below the top, one write or one read a cycle
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[depth_m1[AW-1:0]] <= r_top;
        end
        if (rd_en) begin
            r_rd_data <= mem[depth_m2[AW-1:0]];
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

// ----- hw/rtl/sau_checker.sv -----
module sau_checker #(
    parameter int STACK_DEPTH = sau_pkg::STACK_DEPTH_DEF
) (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          i_in_valid,
    input logic          o_in_ready,
    input sau_pkg::t_in  i_in_data,
    input logic          o_out_valid,
    input logic          i_out_ready,
    input sau_pkg::t_out o_out_data
);

    // A stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("result changed or dropped while stalled");

    // Only one command in work: ready drops after each input transfer
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("input taken while a command is in work");

    // Empty stack reports a zero top
    a_empty_top: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.stack_depth == 7'd0 |-> o_out_data.top_value == '0)
        else $error("non-zero top on empty stack");

    // Depth never exceeds the stack size
    a_depth_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (STACK_DEPTH > 127) ||
                        (o_out_data.stack_depth <= 7'(STACK_DEPTH)))
        else $error("depth beyond stack size");

    // Reset leaves no result pending
    a_reset: assert property (@(posedge i_clk) !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

endmodule

bind stack_arithmetic_unit sau_checker #(.STACK_DEPTH(STACK_DEPTH)) u_sau_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .i_in_data   (i_in_data),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);
